// File: sv/obb_pkg.sv
package obb_pkg;

    typedef struct packed {
        logic [59:0] a_center;
        logic [47:0] a_axis_u;
        logic [47:0] a_axis_v;
        logic [47:0] a_axis_w;
        logic [59:0] a_extents;
        logic [59:0] b_center;
        logic [47:0] b_axis_u;
        logic [47:0] b_axis_v;
        logic [47:0] b_axis_w;
        logic [59:0] b_extents;
    } in_item_t;

    typedef struct packed {
        logic       overlap;
        logic [3:0] separating_axis;
    } out_item_t;

    localparam int NUM_AXES = 15;
    localparam logic [3:0] SEP_NONE = 4'd15;

    // stage handshake toward a register stage
    typedef struct packed {
        logic en;
        logic valid;
    } stg_ctrl_t;

endpackage

// File: sv/obb_prep.sv
module obb_prep
    import obb_pkg::*;
#(
    parameter int CB = 20,
    parameter int AB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stg_ctrl_t            ctrl,
    input  in_item_t             item,
    output logic                 valid_out,
    output logic signed [CB:0]   d [3],
    output logic signed [CB-1:0] ea [3],
    output logic signed [CB-1:0] eb [3],
    output logic signed [AB-1:0] ax [3][3],
    output logic signed [AB-1:0] bx [3][3]
);

    logic                 valid_reg;
    logic signed [CB:0]   d_reg [3];
    logic signed [CB:0]   d_next [3];
    logic signed [CB-1:0] ea_reg [3];
    logic signed [CB-1:0] ea_next [3];
    logic signed [CB-1:0] eb_reg [3];
    logic signed [CB-1:0] eb_next [3];
    logic signed [AB-1:0] ax_reg [3][3];
    logic signed [AB-1:0] ax_next [3][3];
    logic signed [AB-1:0] bx_reg [3][3];
    logic signed [AB-1:0] bx_next [3][3];
    logic [47:0]          aw [3];
    logic [47:0]          bw [3];

    always_comb
    begin
        logic signed [CB-1:0] ac;
        logic signed [CB-1:0] bc;
        aw[0] = item.a_axis_u;
        aw[1] = item.a_axis_v;
        aw[2] = item.a_axis_w;
        bw[0] = item.b_axis_u;
        bw[1] = item.b_axis_v;
        bw[2] = item.b_axis_w;
        for (int k = 0; k < 3; k++)
        begin
            ac = $signed(item.a_center[k*CB +: CB]);
            bc = $signed(item.b_center[k*CB +: CB]);
            d_next[k]  = (CB+1)'(bc) - (CB+1)'(ac);
            ea_next[k] = $signed(item.a_extents[k*CB +: CB]);
            eb_next[k] = $signed(item.b_extents[k*CB +: CB]);
            for (int i = 0; i < 3; i++)
            begin
                ax_next[i][k] = $signed(aw[i][k*AB +: AB]);
                bx_next[i][k] = $signed(bw[i][k*AB +: AB]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.en)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            d_reg  <= d_next;
            ea_reg <= ea_next;
            eb_reg <= eb_next;
            ax_reg <= ax_next;
            bx_reg <= bx_next;
        end
    end

    assign valid_out = valid_reg;
    assign d  = d_reg;
    assign ea = ea_reg;
    assign eb = eb_reg;
    assign ax = ax_reg;
    assign bx = bx_reg;

endmodule

// File: sv/obb_proj.sv
module obb_proj
    import obb_pkg::*;
#(
    parameter int CB = 20,
    parameter int AB = 16,
    parameter int TW = CB + AB + 3,
    parameter int RW = 2 * AB + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stg_ctrl_t            ctrl,
    input  logic signed [CB:0]   d [3],
    input  logic signed [CB-1:0] ea_in [3],
    input  logic signed [CB-1:0] eb_in [3],
    input  logic signed [AB-1:0] ax [3][3],
    input  logic signed [AB-1:0] bx [3][3],
    output logic                 valid_out,
    output logic signed [TW-1:0] t [3],
    output logic signed [RW-1:0] r [3][3],
    output logic signed [CB-1:0] ea [3],
    output logic signed [CB-1:0] eb [3]
);

    logic                 valid_reg;
    logic signed [TW-1:0] t_reg [3];
    logic signed [TW-1:0] t_next [3];
    logic signed [RW-1:0] r_reg [3][3];
    logic signed [RW-1:0] r_next [3][3];
    logic signed [CB-1:0] ea_reg [3];
    logic signed [CB-1:0] eb_reg [3];

    // t: A axes against center offset; r: A axes against B axes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_next[i] = TW'(d[0]) * TW'(ax[i][0]) + TW'(d[1]) * TW'(ax[i][1])
                      + TW'(d[2]) * TW'(ax[i][2]);
            for (int j = 0; j < 3; j++)
                r_next[i][j] = RW'(ax[i][0]) * RW'(bx[j][0])
                             + RW'(ax[i][1]) * RW'(bx[j][1])
                             + RW'(ax[i][2]) * RW'(bx[j][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.en)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            t_reg  <= t_next;
            r_reg  <= r_next;
            ea_reg <= ea_in;
            eb_reg <= eb_in;
        end
    end

    assign valid_out = valid_reg;
    assign t  = t_reg;
    assign r  = r_reg;
    assign ea = ea_reg;
    assign eb = eb_reg;

endmodule

// File: sv/obb_prod.sv
module obb_prod
    import obb_pkg::*;
#(
    parameter int CB = 20,
    parameter int TW = 39,
    parameter int RW = 34,
    parameter int PW = CB + RW + 2,
    parameter int SW = TW + RW + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stg_ctrl_t            ctrl_mul,
    input  stg_ctrl_t            ctrl_sum,
    input  logic signed [TW-1:0] t_in [3],
    input  logic signed [RW-1:0] r [3][3],
    input  logic signed [CB-1:0] ea_in [3],
    input  logic signed [CB-1:0] eb_in [3],
    output logic                 mul_valid,
    output logic                 valid_out,
    output logic signed [TW-1:0] t [3],
    output logic signed [PW-1:0] fa_rad [3],
    output logic signed [SW-1:0] fb_s [3],
    output logic signed [PW-1:0] fb_rad [3],
    output logic signed [SW-1:0] cr_s [3][3],
    output logic signed [PW-1:0] cr_rad [3][3],
    output logic signed [CB-1:0] ea [3],
    output logic signed [CB-1:0] eb [3]
);

    // t * r is split into low and high halves of t, summed one stage later
    localparam int LW  = TW / 2;
    localparam int HW  = TW - LW;
    localparam int PLW = LW + RW + 1;
    localparam int PHW = HW + RW;

    logic                  mul_valid_reg;
    logic                  valid_reg;
    logic signed [RW-1:0]  ar [3][3];
    logic signed [PLW-1:0] plo_reg [3][3][3];
    logic signed [PLW-1:0] plo_next [3][3][3];
    logic signed [PHW-1:0] phi_reg [3][3][3];
    logic signed [PHW-1:0] phi_next [3][3][3];
    logic signed [SW-1:0]  pr [3][3][3];
    logic signed [TW-1:0]  t_m_reg [3];
    logic signed [PW-1:0]  fa_rad_m_reg [3];
    logic signed [PW-1:0]  fb_rad_m_reg [3];
    logic signed [PW-1:0]  cr_rad_m_reg [3][3];
    logic signed [CB-1:0]  ea_m_reg [3];
    logic signed [CB-1:0]  eb_m_reg [3];
    logic signed [TW-1:0]  t_reg [3];
    logic signed [PW-1:0]  fa_rad_reg [3];
    logic signed [PW-1:0]  fa_rad_next [3];
    logic signed [SW-1:0]  fb_s_reg [3];
    logic signed [SW-1:0]  fb_s_next [3];
    logic signed [PW-1:0]  fb_rad_reg [3];
    logic signed [PW-1:0]  fb_rad_next [3];
    logic signed [SW-1:0]  cr_s_reg [3][3];
    logic signed [SW-1:0]  cr_s_next [3][3];
    logic signed [PW-1:0]  cr_rad_reg [3][3];
    logic signed [PW-1:0]  cr_rad_next [3][3];
    logic signed [CB-1:0]  ea_reg [3];
    logic signed [CB-1:0]  eb_reg [3];

    always_comb
    begin
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ar[i][j] = r[i][j][RW-1] ? -r[i][j] : r[i][j];
        for (int i = 0; i < 3; i++)
        begin
            fa_rad_next[i] = PW'(eb_in[0]) * PW'(ar[i][0]) + PW'(eb_in[1]) * PW'(ar[i][1])
                           + PW'(eb_in[2]) * PW'(ar[i][2]);
            fb_rad_next[i] = PW'(ea_in[0]) * PW'(ar[0][i]) + PW'(ea_in[1]) * PW'(ar[1][i])
                           + PW'(ea_in[2]) * PW'(ar[2][i]);
        end
        // partial products t[a] * r[b][j]
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                for (int j = 0; j < 3; j++)
                begin
                    plo_next[a][b][j] = PLW'($signed({1'b0, t_in[a][LW-1:0]}))
                                      * PLW'(r[b][j]);
                    phi_next[a][b][j] = PHW'($signed(t_in[a][TW-1:LW])) * PHW'(r[b][j]);
                end
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                cr_rad_next[i][j] = PW'(ea_in[i1]) * PW'(ar[i2][j])
                                  + PW'(ea_in[i2]) * PW'(ar[i1][j])
                                  + PW'(eb_in[j1]) * PW'(ar[i][j2])
                                  + PW'(eb_in[j2]) * PW'(ar[i][j1]);
            end
        end
    end

    always_comb
    begin
        int i1, i2;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                for (int j = 0; j < 3; j++)
                    pr[a][b][j] = (SW'(phi_reg[a][b][j]) <<< LW) + SW'(plo_reg[a][b][j]);
        for (int i = 0; i < 3; i++)
            fb_s_next[i] = pr[0][0][i] + pr[1][1][i] + pr[2][2][i];
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            for (int j = 0; j < 3; j++)
                cr_s_next[i][j] = pr[i2][i1][j] - pr[i1][i2][j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl_mul.en)
                mul_valid_reg <= ctrl_mul.valid;
            if (ctrl_sum.en)
                valid_reg <= ctrl_sum.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_mul.en)
        begin
            t_m_reg      <= t_in;
            plo_reg      <= plo_next;
            phi_reg      <= phi_next;
            fa_rad_m_reg <= fa_rad_next;
            fb_rad_m_reg <= fb_rad_next;
            cr_rad_m_reg <= cr_rad_next;
            ea_m_reg     <= ea_in;
            eb_m_reg     <= eb_in;
        end
        if (ctrl_sum.en)
        begin
            t_reg      <= t_m_reg;
            fa_rad_reg <= fa_rad_m_reg;
            fb_s_reg   <= fb_s_next;
            fb_rad_reg <= fb_rad_m_reg;
            cr_s_reg   <= cr_s_next;
            cr_rad_reg <= cr_rad_m_reg;
            ea_reg     <= ea_m_reg;
            eb_reg     <= eb_m_reg;
        end
    end

    assign mul_valid = mul_valid_reg;
    assign valid_out = valid_reg;
    assign t      = t_reg;
    assign fa_rad = fa_rad_reg;
    assign fb_s   = fb_s_reg;
    assign fb_rad = fb_rad_reg;
    assign cr_s   = cr_s_reg;
    assign cr_rad = cr_rad_reg;
    assign ea     = ea_reg;
    assign eb     = eb_reg;

endmodule

// File: sv/obb_cmp.sv
module obb_cmp
    import obb_pkg::*;
#(
    parameter int CB = 20,
    parameter int AB = 16,
    parameter int TW = 39,
    parameter int PW = 56,
    parameter int SW = 75
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stg_ctrl_t            ctrl_cmp,
    input  stg_ctrl_t            ctrl_enc,
    input  logic signed [TW-1:0] t [3],
    input  logic signed [PW-1:0] fa_rad [3],
    input  logic signed [SW-1:0] fb_s [3],
    input  logic signed [PW-1:0] fb_rad [3],
    input  logic signed [SW-1:0] cr_s [3][3],
    input  logic signed [PW-1:0] cr_rad [3][3],
    input  logic signed [CB-1:0] ea [3],
    input  logic signed [CB-1:0] eb [3],
    output logic                 cmp_valid,
    output logic                 valid_out,
    output out_item_t            result
);

    localparam int F  = AB - 2;
    localparam int CW = SW + AB + 2;

    logic                  cmp_valid_reg;
    logic [NUM_AXES-1:0]   sep_reg;
    logic [NUM_AXES-1:0]   sep_next;
    logic                  enc_valid_reg;
    out_item_t             result_reg;
    out_item_t             result_next;

    // everything compared at 3F fraction bits
    always_comb
    begin
        logic signed [TW-1:0] at;
        logic signed [SW-1:0] as;
        for (int i = 0; i < 3; i++)
        begin
            at = t[i][TW-1] ? -t[i] : t[i];
            sep_next[i] = (CW'(at) <<< (2*F))
                        > ((CW'(ea[i]) <<< (3*F)) + (CW'(fa_rad[i]) <<< F));
            as = fb_s[i][SW-1] ? -fb_s[i] : fb_s[i];
            sep_next[3+i] = CW'(as)
                          > ((CW'(fb_rad[i]) <<< F) + (CW'(eb[i]) <<< (3*F)));
            for (int j = 0; j < 3; j++)
            begin
                as = cr_s[i][j][SW-1] ? -cr_s[i][j] : cr_s[i][j];
                sep_next[6+3*i+j] = CW'(as) > (CW'(cr_rad[i][j]) <<< F);
            end
        end
    end

    // lowest separating axis wins
    always_comb
    begin
        result_next.overlap = 1'b1;
        result_next.separating_axis = SEP_NONE;
        for (int k = NUM_AXES - 1; k >= 0; k--)
        begin
            if (sep_reg[k])
            begin
                result_next.overlap = 1'b0;
                result_next.separating_axis = 4'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            enc_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmp.en)
                cmp_valid_reg <= ctrl_cmp.valid;
            if (ctrl_enc.en)
                enc_valid_reg <= ctrl_enc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmp.en)
            sep_reg <= sep_next;
        if (ctrl_enc.en)
            result_reg <= result_next;
    end

    assign cmp_valid = cmp_valid_reg;
    // encode stage valid is the block's output valid
    assign valid_out = enc_valid_reg;
    assign result    = result_reg;

endmodule

// File: sv/obb_pair_overlap_test_unit.sv
// Oriented box pair overlap test, 15-axis separating axis test on fixed point
// inputs. Six register stages (unpack and center offset, axis projections,
// radius and partial distance products, distance sums, compare, priority
// encode), and one pair can be taken in every cycle while out_stall does
// not back the stages up. Each stage holds its item only while the stage
// behind it is full and blocked, so bubbles close up when out_stall is
// held.
module obb_pair_overlap_test_unit
    import obb_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int AXIS_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int CB = COORD_BITS;
    localparam int AB = AXIS_BITS;
    localparam int TW = CB + AB + 3;
    localparam int RW = 2 * AB + 2;
    localparam int PW = CB + RW + 2;
    localparam int SW = TW + RW + 2;

    logic v1, v2, v3, v4, v5, v6;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    stg_ctrl_t c1, c2, c3, c4, c5, c6;

    logic signed [CB:0]   d [3];
    logic signed [CB-1:0] ea1 [3];
    logic signed [CB-1:0] eb1 [3];
    logic signed [AB-1:0] ax [3][3];
    logic signed [AB-1:0] bx [3][3];
    logic signed [TW-1:0] t2 [3];
    logic signed [RW-1:0] r2 [3][3];
    logic signed [CB-1:0] ea2 [3];
    logic signed [CB-1:0] eb2 [3];
    logic signed [TW-1:0] t3 [3];
    logic signed [PW-1:0] fa_rad [3];
    logic signed [SW-1:0] fb_s [3];
    logic signed [PW-1:0] fb_rad [3];
    logic signed [SW-1:0] cr_s [3][3];
    logic signed [PW-1:0] cr_rad [3][3];
    logic signed [CB-1:0] ea3 [3];
    logic signed [CB-1:0] eb3 [3];

    assign rdy6 = !v6 || !out_stall;
    assign rdy5 = !v5 || rdy6;
    assign rdy4 = !v4 || rdy5;
    assign rdy3 = !v3 || rdy4;
    assign rdy2 = !v2 || rdy3;
    assign rdy1 = !v1 || rdy2;

    assign c1 = '{en: rdy1, valid: in_valid};
    assign c2 = '{en: rdy2, valid: v1};
    assign c3 = '{en: rdy3, valid: v2};
    assign c4 = '{en: rdy4, valid: v3};
    assign c5 = '{en: rdy5, valid: v4};
    assign c6 = '{en: rdy6, valid: v5};

    obb_prep #(.CB(CB), .AB(AB)) u_prep (
        .clk(clk), .rst_n(rst_n), .ctrl(c1), .item(in_item), .valid_out(v1),
        .d(d), .ea(ea1), .eb(eb1), .ax(ax), .bx(bx)
    );

    obb_proj #(.CB(CB), .AB(AB), .TW(TW), .RW(RW)) u_proj (
        .clk(clk), .rst_n(rst_n), .ctrl(c2), .d(d), .ea_in(ea1), .eb_in(eb1),
        .ax(ax), .bx(bx), .valid_out(v2), .t(t2), .r(r2), .ea(ea2), .eb(eb2)
    );

    obb_prod #(.CB(CB), .TW(TW), .RW(RW), .PW(PW), .SW(SW)) u_prod (
        .clk(clk), .rst_n(rst_n), .ctrl_mul(c3), .ctrl_sum(c4), .t_in(t2), .r(r2),
        .ea_in(ea2), .eb_in(eb2), .mul_valid(v3), .valid_out(v4), .t(t3),
        .fa_rad(fa_rad), .fb_s(fb_s), .fb_rad(fb_rad),
        .cr_s(cr_s), .cr_rad(cr_rad), .ea(ea3), .eb(eb3)
    );

    obb_cmp #(.CB(CB), .AB(AB), .TW(TW), .PW(PW), .SW(SW)) u_cmp (
        .clk(clk), .rst_n(rst_n), .ctrl_cmp(c5), .ctrl_enc(c6),
        .t(t3), .fa_rad(fa_rad), .fb_s(fb_s), .fb_rad(fb_rad),
        .cr_s(cr_s), .cr_rad(cr_rad), .ea(ea3), .eb(eb3),
        .cmp_valid(v5), .valid_out(v6), .result(out_item)
    );

    assign in_stall  = !rdy1;
    assign out_valid = v6;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import obb_pkg::*;

    typedef logic signed [127:0] wide_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    out_item_t expected_results[$];
    int        errors;
    int        burst_left;

    obb_pair_overlap_test_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor: exact SAT on 128-bit signed values
    // ---------------------------------------------------------------
    function automatic wide_t coord_of(logic [59:0] w, int k);
        logic [19:0] f;
        f = w[k*20 +: 20];
        return {{108{f[19]}}, f};
    endfunction

    function automatic wide_t comp_of(logic [47:0] w, int k);
        logic [15:0] f;
        f = w[k*16 +: 16];
        return {{112{f[15]}}, f};
    endfunction

    function automatic wide_t mag(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic out_item_t predict_overlap(in_item_t it);
        wide_t ac[3], bc[3], ea[3], eb[3], d[3], t[3];
        wide_t ax[3][3], bx[3][3], r[3][3];
        wide_t lhs, rhs, s, rad;
        logic [47:0] aw[3], bw[3];
        int sep;
        int i1, i2, j1, j2;
        out_item_t res;
        aw[0] = it.a_axis_u; aw[1] = it.a_axis_v; aw[2] = it.a_axis_w;
        bw[0] = it.b_axis_u; bw[1] = it.b_axis_v; bw[2] = it.b_axis_w;
        sep = -1;
        for (int k = 0; k < 3; k++)
        begin
            ac[k] = coord_of(it.a_center, k);
            bc[k] = coord_of(it.b_center, k);
            ea[k] = coord_of(it.a_extents, k);
            eb[k] = coord_of(it.b_extents, k);
            d[k]  = bc[k] - ac[k];
            for (int i = 0; i < 3; i++)
            begin
                ax[i][k] = comp_of(aw[i], k);
                bx[i][k] = comp_of(bw[i], k);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            t[i] = d[0]*ax[i][0] + d[1]*ax[i][1] + d[2]*ax[i][2];
            for (int j = 0; j < 3; j++)
                r[i][j] = ax[i][0]*bx[j][0] + ax[i][1]*bx[j][1] + ax[i][2]*bx[j][2];
        end
        // face axes of A
        for (int i = 0; i < 3 && sep < 0; i++)
        begin
            lhs = mag(t[i]) << 28;
            rhs = 0;
            for (int j = 0; j < 3; j++)
                rhs = rhs + eb[j] * mag(r[i][j]);
            rhs = (ea[i] << 42) + (rhs << 14);
            if (lhs > rhs)
                sep = i;
        end
        // face axes of B
        for (int j = 0; j < 3 && sep < 0; j++)
        begin
            s = 0;
            rad = 0;
            for (int i = 0; i < 3; i++)
            begin
                s = s + t[i] * r[i][j];
                rad = rad + ea[i] * mag(r[i][j]);
            end
            if (mag(s) > (rad << 14) + (eb[j] << 42))
                sep = 3 + j;
        end
        // edge cross products
        for (int i = 0; i < 3 && sep < 0; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3 && sep < 0; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                rad = ea[i1]*mag(r[i2][j]) + ea[i2]*mag(r[i1][j])
                    + eb[j1]*mag(r[i][j2]) + eb[j2]*mag(r[i][j1]);
                s = t[i2]*r[i1][j] - t[i1]*r[i2][j];
                if (mag(s) > (rad << 14))
                    sep = 6 + 3*i + j;
            end
        end
        if (sep < 0)
        begin
            res.overlap = 1'b1;
            res.separating_axis = SEP_NONE;
        end
        else
        begin
            res.overlap = 1'b0;
            res.separating_axis = 4'(sep);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // item builders
    // ---------------------------------------------------------------
    function automatic logic [59:0] pack_coord(int x, int y, int z);
        return {20'(z), 20'(y), 20'(x)};
    endfunction

    function automatic logic [47:0] pack_axis(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic int to_q14(real x);
        return $rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5));
    endfunction

    function automatic real pick_angle();
        if ($urandom_range(0, 3) == 0)
            return 1.5707963267948966 * $urandom_range(0, 3);
        return $urandom_range(0, 35999) * 3.141592653589793 / 18000.0;
    endfunction

    function automatic void rotated_axes(output logic [47:0] u, output logic [47:0] v,
                                         output logic [47:0] w);
        real a, b, c, ca, sa, cb, sb, cc, sc;
        a = pick_angle(); b = pick_angle(); c = pick_angle();
        ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cc = $cos(c); sc = $sin(c);
        u = pack_axis(to_q14(cb*cc), to_q14(cb*sc), to_q14(-sb));
        v = pack_axis(to_q14(sa*sb*cc - ca*sc), to_q14(sa*sb*sc + ca*cc), to_q14(sa*cb));
        w = pack_axis(to_q14(ca*sb*cc + sa*sc), to_q14(ca*sb*sc - sa*cc), to_q14(ca*cb));
    endfunction

    function automatic int rand_signed(int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    function automatic logic [59:0] rand_extents();
        int lim;
        lim = ($urandom_range(0, 15) == 0) ? 200000 : 2000;
        return pack_coord($urandom_range(0, lim), $urandom_range(0, lim),
                          $urandom_range(0, lim));
    endfunction

    function automatic in_item_t identity_pair(int dx, int dy, int dz, int ext);
        in_item_t it;
        it.a_center  = pack_coord(0, 0, 0);
        it.b_center  = pack_coord(dx, dy, dz);
        it.a_axis_u  = pack_axis(16384, 0, 0);
        it.a_axis_v  = pack_axis(0, 16384, 0);
        it.a_axis_w  = pack_axis(0, 0, 16384);
        it.b_axis_u  = it.a_axis_u;
        it.b_axis_v  = it.a_axis_v;
        it.b_axis_w  = it.a_axis_w;
        it.a_extents = pack_coord(ext, ext, ext);
        it.b_extents = pack_coord(ext, ext, ext);
        return it;
    endfunction

    // ---------------------------------------------------------------
    // send / drain
    // ---------------------------------------------------------------
    task automatic send_pair(in_item_t it);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_overlap(it));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_extremes();
        in_item_t it;
        send_pair('0);
        send_pair('1);
        it.a_center = {3{20'h7FFFF}}; it.b_center = {3{20'h80000}};
        it.a_axis_u = {3{16'h7FFF}};  it.a_axis_v = {3{16'h8000}};
        it.a_axis_w = {3{16'h7FFF}};  it.b_axis_u = {3{16'h8000}};
        it.b_axis_v = {3{16'h7FFF}};  it.b_axis_w = {3{16'h8000}};
        it.a_extents = {3{20'h7FFFF}}; it.b_extents = {3{20'h7FFFF}};
        send_pair(it);
        it.a_extents = {3{20'h80000}}; it.b_extents = {3{20'h00000}};
        send_pair(it);
        it.a_center = {3{20'h80000}}; it.b_center = {3{20'h7FFFF}};
        it.a_extents = '0;
        send_pair(it);
    endtask

    task automatic test_face_axes();
        // unit boxes touching exactly, then apart along each axis, then overlapping
        send_pair(identity_pair(512, 0, 0, 256));
        send_pair(identity_pair(513, 0, 0, 256));
        send_pair(identity_pair(0, -513, 0, 256));
        send_pair(identity_pair(0, 0, 600, 256));
        send_pair(identity_pair(100, 100, 100, 256));
    endtask

    task automatic test_special_cases();
        in_item_t it;
        // negative extents
        it = identity_pair(0, 0, 0, -256);
        send_pair(it);
        it = identity_pair(10, 0, 0, 256);
        it.b_extents = pack_coord(-300, 256, 256);
        send_pair(it);
        // non-unit, non-orthogonal axes
        it = identity_pair(300, 200, -100, 256);
        it.a_axis_u = pack_axis(30000, 5000, -7000);
        it.a_axis_v = pack_axis(30000, 5000, -7000);
        it.b_axis_w = pack_axis(-12, 20000, 3);
        send_pair(it);
        // parallel edges: degenerate cross axes, zero offset
        it = identity_pair(0, 0, 0, 0);
        send_pair(it);
        // B rotated 45 deg about z, placed near A's corner
        it = identity_pair(700, 700, 0, 256);
        it.b_axis_u = pack_axis(11585, 11585, 0);
        it.b_axis_v = pack_axis(-11585, 11585, 0);
        send_pair(it);
        it.b_center = pack_coord(880, 0, 0);
        send_pair(it);
        // zero axes
        it = identity_pair(1, 0, 0, 0);
        it.a_axis_u = '0; it.b_axis_u = '0;
        send_pair(it);
    endtask

    task automatic test_random_rotated(int count);
        in_item_t it;
        int span;
        for (int n = 0; n < count; n++)
        begin
            span = $urandom_range(0, 1) ? 1500 : 4000;
            rotated_axes(it.a_axis_u, it.a_axis_v, it.a_axis_w);
            rotated_axes(it.b_axis_u, it.b_axis_v, it.b_axis_w);
            it.a_center  = pack_coord(rand_signed(span), rand_signed(span), rand_signed(span));
            it.b_center  = pack_coord(rand_signed(span), rand_signed(span), rand_signed(span));
            it.a_extents = rand_extents();
            it.b_extents = rand_extents();
            if ($urandom_range(0, 9) == 0)
                it.b_axis_u = it.a_axis_u;
            send_pair(it);
        end
    endtask

    task automatic test_random_raw(int count);
        in_item_t it;
        for (int n = 0; n < count; n++)
        begin
            it.a_center  = 60'({$urandom(), $urandom()});
            it.a_axis_u  = 48'({$urandom(), $urandom()});
            it.a_axis_v  = 48'({$urandom(), $urandom()});
            it.a_axis_w  = 48'({$urandom(), $urandom()});
            it.a_extents = 60'({$urandom(), $urandom()});
            it.b_center  = 60'({$urandom(), $urandom()});
            it.b_axis_u  = 48'({$urandom(), $urandom()});
            it.b_axis_v  = 48'({$urandom(), $urandom()});
            it.b_axis_w  = 48'({$urandom(), $urandom()});
            it.b_extents = 60'({$urandom(), $urandom()});
            send_pair(it);
        end
    endtask

    // ---------------------------------------------------------------
    // receiver stall pattern and result checker
    // ---------------------------------------------------------------
    int stall_mode;
    int stall_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count % 97 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= (stall_count % 5 < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: overlap %0b axis %0d",
                       out_item.overlap, out_item.separating_axis);
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_item.overlap !== exp_res.overlap)
                begin
                    $error("overlap: expected %0b, got %0b", exp_res.overlap,
                           out_item.overlap);
                    errors++;
                end
                if (out_item.separating_axis !== exp_res.separating_axis)
                begin
                    $error("separating_axis: expected %0d, got %0d",
                           exp_res.separating_axis, out_item.separating_axis);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors     = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_face_axes();
        test_special_cases();
        wait_drained();
        test_random_rotated(1500);
        wait_drained();
        test_random_raw(430);
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
